// File: rtl/tmtw_pkg.sv
// Package for the text-mode terminal writer.
// Holds operation and character codes, the command kinds and the command word.
// No dependencies.
package tmtw_pkg;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    localparam logic [7:0] RESET_COLOR = 8'hF0;

    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int VALUE_W = 16;
    localparam int CROW_W  = 5;
    localparam int CCOL_W  = 7;

    typedef enum logic [2:0] {
        K_NOP,
        K_GLYPH,
        K_NEWLINE,
        K_TAB,
        K_READ,
        K_CLEAR
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CHAR_W-1:0]   ch;
        logic [INDEX_W-1:0]  index;
    } t_cmd;

endpackage

// File: rtl/text_mode_terminal_writer_unit.sv
// Text-mode terminal writer: a put passes through the back-end states S_PUT and S_FINISH, a read
// through S_READ and S_FINISH, a newline or an ignored word straight to S_FINISH; a tab writes
// TAB_SPACES cells, one S_PUT state per cell write; new commands wait for S_IDLE. Configuration is taken anytime.
// A scroll adds a blanking sweep of COLS cells and a clear a sweep of all ROWS*COLS cells.
// Results are held in an output register while the next items queue up.
// Reset is synchronous, active low; a blanking pass over all ROWS*COLS cells (1920 by default) follows.
module text_mode_terminal_writer_unit #(
    parameter int ROWS       = 24,
    parameter int COLS       = 80,
    parameter int TAB_SPACES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_code[7:0], cell_index[18:8]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cell_value[15:0], cursor_row[20:16], cursor_col[27:21]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data      // text_color[7:0]
);
    import tmtw_pkg::*;

    logic [7:0] r_color;
    t_cmd       w_cmd;
    logic       w_cmd_valid;
    logic       w_cmd_ready;
    logic       w_init;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= RESET_COLOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_color <= i_cfg_data;
        end
    end

    tmtw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_init        (w_init),
        .o_cmd         (w_cmd),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready)
    );

    tmtw_back #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .TAB_SPACES (TAB_SPACES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_color     (r_color),
        .o_init      (w_init),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init |-> !s_axis_tready)
        else $error("input accepted during blanking pass");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[27:21]) < COLS))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[20:16]) < ROWS))
        else $error("cursor row out of range");

    a_init_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_init) && w_init |-> !$rose(m_axis_tvalid))
        else $error("result produced during blanking pass");

endmodule

// File: rtl/tmtw_front.sv
// Front end of the terminal writer: accepts input words, classifies them
// into commands and holds them in a two-entry queue for the back end.
// Depends on tmtw_pkg.
module tmtw_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // char_code[7:0], cell_index[18:8]
    input  logic [1:0]           s_axis_tuser,   // operation[1:0]
    input  logic                 i_init,
    output tmtw_pkg::t_cmd       o_cmd,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready
);
    import tmtw_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cmd.ch    = s_axis_tdata[7:0];
        w_cmd.index = s_axis_tdata[18:8];
        case (s_axis_tuser)
            OP_PUT: begin
                if (s_axis_tdata[7:0] == CH_NUL) begin
                    w_cmd.kind = K_NOP;
                end else if (s_axis_tdata[7:0] == CH_NEWLINE) begin
                    w_cmd.kind = K_NEWLINE;
                end else if (s_axis_tdata[7:0] == CH_TAB) begin
                    w_cmd.kind = K_TAB;
                end else begin
                    w_cmd.kind = K_GLYPH;
                end
            end
            OP_READ:  w_cmd.kind = K_READ;
            OP_CLEAR: w_cmd.kind = K_CLEAR;
            default:  w_cmd.kind = K_NOP;
        endcase
    end

    assign s_axis_tready = (r_count != 2'd2) && !i_init;
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_count != 2'd0);
    assign w_pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd         = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: rtl/tmtw_back.sv
// Back end of the terminal writer: screen memory with a rotating top-row
// offset, cursor, blanking sweeps and the registered result word.
// Depends on tmtw_pkg.
module tmtw_back #(
    parameter int ROWS       = 24,
    parameter int COLS       = 80,
    parameter int TAB_SPACES = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tmtw_pkg::t_cmd       i_cmd,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  logic [7:0]           i_color,
    output logic                 o_init,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_out_data
);
    import tmtw_pkg::*;

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int TAB_W  = $clog2(TAB_SPACES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_SWEEP,
        S_READ,
        S_FINISH
    } t_state;

    logic [VALUE_W-1:0] r_mem [CELLS];
    logic [VALUE_W-1:0] r_rd_data;

    t_state             r_state,       n_state;
    logic               r_init,        n_init;
    logic [ROW_W-1:0]   r_row,         n_row;
    logic [COL_W-1:0]   r_col,         n_col;
    logic [ADDR_W-1:0]  r_top,         n_top;
    logic [TAB_W-1:0]   r_tab_left,    n_tab_left;
    logic [7:0]         r_ch,          n_ch;
    logic [ADDR_W-1:0]  r_sweep_addr,  n_sweep_addr;
    logic [ADDR_W-1:0]  r_sweep_end,   n_sweep_end;
    logic [7:0]         r_sweep_color, n_sweep_color;
    logic               r_in_range,    n_in_range;
    logic [VALUE_W-1:0] r_value,       n_value;
    logic               r_out_valid,   n_out_valid;
    logic [31:0]        r_out_data,    n_out_data;

    logic [ADDR_W-1:0]  w_cur_lin;
    logic [ADDR_W:0]    w_cur_sum;
    logic [ADDR_W-1:0]  w_cur_phys;
    logic [ADDR_W:0]    w_idx_sum;
    logic [ADDR_W-1:0]  w_idx_phys;
    logic [ADDR_W:0]    w_top_sum;
    logic [ADDR_W-1:0]  w_top_next;
    logic               w_last_row;
    logic               w_last_col;
    logic [TAB_W-1:0]   w_tab_dec;
    logic               w_wr_en;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [VALUE_W-1:0] w_wr_data;

    // map logical cell addresses onto the rotated store
    always_comb begin
        w_cur_lin  = ADDR_W'(r_row * COLS) + ADDR_W'(r_col);
        w_cur_sum  = {1'b0, w_cur_lin} + {1'b0, r_top};
        w_cur_phys = (w_cur_sum >= (ADDR_W+1)'(CELLS)) ?
                     ADDR_W'(w_cur_sum - (ADDR_W+1)'(CELLS)) : ADDR_W'(w_cur_sum);
        w_idx_sum  = {1'b0, ADDR_W'(i_cmd.index)} + {1'b0, r_top};
        w_idx_phys = (w_idx_sum >= (ADDR_W+1)'(CELLS)) ?
                     ADDR_W'(w_idx_sum - (ADDR_W+1)'(CELLS)) : ADDR_W'(w_idx_sum);
        w_top_sum  = {1'b0, r_top} + (ADDR_W+1)'(COLS);
        w_top_next = (w_top_sum >= (ADDR_W+1)'(CELLS)) ? '0 : ADDR_W'(w_top_sum);
        w_last_row = (r_row == ROW_W'(ROWS - 1));
        w_last_col = (r_col == COL_W'(COLS - 1));
        w_tab_dec  = r_tab_left - TAB_W'(1);
    end

    always_comb begin
        w_wr_en   = (r_state == S_PUT) || (r_state == S_SWEEP);
        w_wr_addr = (r_state == S_PUT) ? w_cur_phys : r_sweep_addr;
        w_wr_data = (r_state == S_PUT) ? {i_color, r_ch} : {r_sweep_color, CH_SPACE};
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_idx_phys];
    end

    always_comb begin
        n_state       = r_state;
        n_init        = r_init;
        n_row         = r_row;
        n_col         = r_col;
        n_top         = r_top;
        n_tab_left    = r_tab_left;
        n_ch          = r_ch;
        n_sweep_addr  = r_sweep_addr;
        n_sweep_end   = r_sweep_end;
        n_sweep_color = r_sweep_color;
        n_in_range    = r_in_range;
        n_value       = r_value;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_value    = '0;
                    n_tab_left = '0;
                    case (i_cmd.kind)
                        K_GLYPH: begin
                            n_ch       = i_cmd.ch;
                            n_tab_left = TAB_W'(1);
                            n_state    = S_PUT;
                        end
                        K_TAB: begin
                            n_ch       = CH_SPACE;
                            n_tab_left = TAB_W'(TAB_SPACES);
                            n_state    = S_PUT;
                        end
                        K_NEWLINE: begin
                            n_col = '0;
                            if (w_last_row) begin
                                n_sweep_addr  = r_top;
                                n_sweep_end   = r_top + ADDR_W'(COLS - 1);
                                n_sweep_color = i_color;
                                n_top         = w_top_next;
                                n_state       = S_SWEEP;
                            end else begin
                                n_row   = r_row + ROW_W'(1);
                                n_state = S_FINISH;
                            end
                        end
                        K_READ: begin
                            n_in_range = ({21'd0, i_cmd.index} < 32'(CELLS));
                            n_state    = S_READ;
                        end
                        K_CLEAR: begin
                            n_row         = '0;
                            n_col         = '0;
                            n_top         = '0;
                            n_sweep_addr  = '0;
                            n_sweep_end   = ADDR_W'(CELLS - 1);
                            n_sweep_color = i_color;
                            n_state       = S_SWEEP;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_PUT: begin
                n_tab_left = w_tab_dec;
                n_state    = (w_tab_dec != '0) ? S_PUT : S_FINISH;
                if (w_last_col) begin
                    n_col = '0;
                    if (w_last_row) begin
                        n_sweep_addr  = r_top;
                        n_sweep_end   = r_top + ADDR_W'(COLS - 1);
                        n_sweep_color = i_color;
                        n_top         = w_top_next;
                        n_state       = S_SWEEP;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            S_SWEEP: begin
                n_sweep_addr = r_sweep_addr + ADDR_W'(1);
                if (r_sweep_addr == r_sweep_end) begin
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else if (r_tab_left != '0) begin
                        n_state = S_PUT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_READ: begin
                n_value = r_in_range ? r_rd_data : '0;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'd0, CCOL_W'(r_col), CROW_W'(r_row), r_value};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_SWEEP;
            r_init        <= 1'b1;
            r_row         <= '0;
            r_col         <= '0;
            r_top         <= '0;
            r_tab_left    <= '0;
            r_sweep_addr  <= '0;
            r_sweep_end   <= ADDR_W'(CELLS - 1);
            r_sweep_color <= RESET_COLOR;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_init        <= n_init;
            r_row         <= n_row;
            r_col         <= n_col;
            r_top         <= n_top;
            r_tab_left    <= n_tab_left;
            r_sweep_addr  <= n_sweep_addr;
            r_sweep_end   <= n_sweep_end;
            r_sweep_color <= n_sweep_color;
            r_out_valid   <= n_out_valid;
        end
        r_ch       <= n_ch;
        r_in_range <= n_in_range;
        r_value    <= n_value;
        r_out_data <= n_out_data;
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_init      = r_init;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: tb/text_mode_terminal_writer_unit_tb.sv
// Self-checking testbench for the text-mode terminal writer: a directed table, then random put/read/clear/unused
// words under random stalls, calm in the last phase, checked against an in-bench screen predictor.
// Depends on tmtw_pkg and text_mode_terminal_writer_unit.
module text_mode_terminal_writer_unit_tb;
    import tmtw_pkg::*;

    localparam int ROWS        = 24;
    localparam int COLS        = 80;
    localparam int TAB_SPACES  = 4;
    localparam int CELLS       = ROWS * COLS;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_WAIT  = 2100;
    localparam int PHASE_ITEMS = 350;
    localparam int N_DIRECTED  = 20;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [CROW_W-1:0]  row;
        logic [CCOL_W-1:0]  col;
    } t_cell_report;

    typedef struct packed {
        logic [1:0]         op;
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] idx;
        logic               typed;
        t_cell_report       report;
    } t_directed_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    logic [VALUE_W-1:0] screen_image [CELLS];
    int unsigned        cur_row;
    int unsigned        cur_col;
    logic [7:0]         paint_color;

    t_cell_report cell_reports_q [$];
    int           error_count;
    int           accepted_count;
    int unsigned  cycle_count;
    bit           calm;
    bit           pressure_done;

    t_directed_row directed_rows [N_DIRECTED] = '{
        '{OP_READ,   CH_NUL,     11'd0,    1'b1, '{16'hF020, 5'd0, 7'd0}},
        '{OP_READ,   CH_NUL,     11'd1919, 1'b1, '{16'hF020, 5'd0, 7'd0}},
        '{OP_READ,   CH_NUL,     11'd1920, 1'b1, '{16'h0000, 5'd0, 7'd0}},
        '{OP_READ,   8'hFF,      11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0}},
        '{OP_UNUSED, 8'hFF,      11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0}},
        '{OP_PUT,    CH_NUL,     11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0}},
        '{OP_PUT,    8'h41,      11'd0,    1'b1, '{16'h0000, 5'd0, 7'd1}},
        '{OP_READ,   CH_NUL,     11'd0,    1'b1, '{16'hF041, 5'd0, 7'd1}},
        '{OP_PUT,    8'hFF,      11'd0,    1'b1, '{16'h0000, 5'd0, 7'd2}},
        '{OP_PUT,    8'h80,      11'd1024, 1'b1, '{16'h0000, 5'd0, 7'd3}},
        '{OP_PUT,    CH_TAB,     11'd0,    1'b1, '{16'h0000, 5'd0, 7'd7}},
        '{OP_READ,   CH_NUL,     11'd6,    1'b1, '{16'hF020, 5'd0, 7'd7}},
        '{OP_PUT,    CH_NEWLINE, 11'd0,    1'b1, '{16'h0000, 5'd1, 7'd0}},
        '{OP_PUT,    8'h01,      11'd0,    1'b1, '{16'h0000, 5'd1, 7'd1}},
        '{OP_PUT,    8'h7F,      11'd0,    1'b0, '{16'h0000, 5'd0, 7'd0}},
        '{OP_READ,   CH_NUL,     11'd80,   1'b1, '{16'hF001, 5'd1, 7'd2}},
        '{OP_READ,   CH_NUL,     11'd2,    1'b1, '{16'hF080, 5'd1, 7'd2}},
        '{OP_CLEAR,  8'h55,      11'd1365, 1'b1, '{16'h0000, 5'd0, 7'd0}},
        '{OP_READ,   CH_NUL,     11'd80,   1'b1, '{16'hF020, 5'd0, 7'd0}},
        '{OP_PUT,    CH_SPACE,   11'd682,  1'b1, '{16'h0000, 5'd0, 7'd1}}
    };

    text_mode_terminal_writer_unit #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .TAB_SPACES (TAB_SPACES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) screen_image[i] = {paint_color, CH_SPACE};
    endfunction

    function automatic void advance_row();
        cur_row++;
        if (cur_row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_image[i] = screen_image[i + COLS];
            for (int i = 0; i < COLS; i++) screen_image[(ROWS - 1) * COLS + i] = {paint_color, CH_SPACE};
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic void stamp_glyph(logic [7:0] ch);
        screen_image[cur_row * COLS + cur_col] = {paint_color, ch};
        cur_col++;
        if (cur_col >= COLS) begin
            cur_col = 0;
            advance_row();
        end
    endfunction

    function automatic t_cell_report terminal_apply(logic [1:0] op, logic [7:0] ch,
                                                    logic [INDEX_W-1:0] idx);
        t_cell_report r;
        r = '0;
        case (op)
            OP_PUT: begin
                if (ch == CH_NEWLINE) begin
                    cur_col = 0;
                    advance_row();
                end else if (ch == CH_TAB) begin
                    for (int k = 0; k < TAB_SPACES; k++) stamp_glyph(CH_SPACE);
                end else if (ch != CH_NUL) begin
                    stamp_glyph(ch);
                end
            end
            OP_READ: begin
                if (idx < CELLS) r.value = screen_image[idx];
            end
            OP_CLEAR: begin
                blank_screen();
                cur_row = 0;
                cur_col = 0;
            end
            default: ;
        endcase
        r.row = cur_row[CROW_W-1:0];
        r.col = cur_col[CCOL_W-1:0];
        return r;
    endfunction

    task automatic offer_word(logic [1:0] op, logic [7:0] ch, logic [INDEX_W-1:0] idx,
                              logic typed, t_cell_report typed_report);
        t_cell_report r;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, idx, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        r = terminal_apply(op, ch, idx);
        if (typed) r = typed_report;
        cell_reports_q.push_back(r);
        accepted_count++;
    endtask

    task automatic wait_drained();
        while (cell_reports_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_text_color(logic [7:0] color);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= color;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        paint_color = color;
    endtask

    task automatic random_words(int count);
        int                 pick;
        int                 sel;
        int unsigned        base;
        int unsigned        back;
        logic [1:0]         op;
        logic [7:0]         ch;
        logic [INDEX_W-1:0] idx;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 199);
            sel  = $urandom_range(0, 99);
            ch   = 8'($urandom_range(0, 255));
            idx  = INDEX_W'($urandom_range(0, 2047));
            if (pick < 2) begin
                op = OP_CLEAR;
            end else if (pick < 6) begin
                op = OP_UNUSED;
            end else if (pick < 42) begin
                op = OP_READ;
                if (sel < 50) begin
                    base = cur_row * COLS + cur_col;
                    back = $urandom_range(0, 100);
                    idx  = INDEX_W'((base >= back) ? base - back : base);
                end else if (sel < 95) begin
                    idx = INDEX_W'($urandom_range(0, CELLS - 1));
                end else begin
                    idx = INDEX_W'($urandom_range(CELLS, 2047));
                end
            end else begin
                op = OP_PUT;
                if (sel < 12) ch = CH_NEWLINE;
                else if (sel < 20) ch = CH_TAB;
                else if (sel < 22) ch = CH_NUL;
            end
            offer_word(op, ch, idx, 1'b0, '0);
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= OP_PUT;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        error_count    = 0;
        accepted_count = 0;
        calm           = 1'b0;
        paint_color    = RESET_COLOR;
        cur_row        = 0;
        cur_col        = 0;
        blank_screen();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_DIRECTED; n++)
            offer_word(directed_rows[n].op, directed_rows[n].ch, directed_rows[n].idx,
                       directed_rows[n].typed, directed_rows[n].report);

        set_text_color(8'h00);
        random_words(PHASE_ITEMS);
        set_text_color(8'hFF);
        random_words(PHASE_ITEMS);
        set_text_color(8'($urandom_range(0, 255)));
        random_words(PHASE_ITEMS);
        set_text_color(8'h1E);
        random_words(PHASE_ITEMS);
        set_text_color(8'($urandom_range(0, 255)));
        calm = 1'b1;
        random_words(PHASE_ITEMS);

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (error_count == 0)
            $display("text_mode_terminal_writer_unit_tb OK");
        else
            $display("text_mode_terminal_writer_unit_tb NOT OK");
        $finish;
    end

    initial begin
        pressure_done = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!pressure_done && accepted_count >= 600) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                pressure_done = 1'b1;
            end else if (calm || $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_cell_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cell_reports_q.size() == 0) begin
                $error("unexpected word %h", m_axis_tdata);
                error_count++;
            end else begin
                want = cell_reports_q.pop_front();
                if (m_axis_tdata[15:0] !== want.value) begin
                    $error("cell_value: expected %h, got %h", want.value, m_axis_tdata[15:0]);
                    error_count++;
                end
                if (m_axis_tdata[20:16] !== want.row) begin
                    $error("cursor_row: expected %0d, got %0d", want.row, m_axis_tdata[20:16]);
                    error_count++;
                end
                if (m_axis_tdata[27:21] !== want.col) begin
                    $error("cursor_col: expected %0d, got %0d", want.col, m_axis_tdata[27:21]);
                    error_count++;
                end
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("text_mode_terminal_writer_unit_tb NOT OK");
            $finish;
        end
    end

endmodule
